FILE: sv/blt_pkg.sv
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types and constants for the buffer lease tracker.
// ----------------------------------------------------------------------------
package blt_pkg;

    localparam int MAX_BUFFERS = 16;
    localparam int BUF_IDX_W   = $clog2(MAX_BUFFERS);
    localparam int BUF_CNT_W   = $clog2(MAX_BUFFERS + 1);
    localparam int NUM_BUF_W   = 5;
    localparam int TIMEOUT_W   = 16;
    localparam int SHARE_W     = 8;
    localparam int AGE_W       = 16;
    localparam int TOTAL_W     = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [NUM_BUF_W-1:0] NUM_BUF_RESET = NUM_BUF_W'(16);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BUFS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TIMEOUT = 1'd1;

    // request codes
    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_COUNT = 2'd2;

    // buffer status codes
    localparam logic [1:0] STAT_IN_GRAPH = 2'd0;
    localparam logic [1:0] STAT_LOCKED   = 2'd1;
    localparam logic [1:0] STAT_FREE     = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [BUF_IDX_W-1:0] buffer_index;
        logic [1:0]           requested_status;
        logic                 already_enqueued;
    } t_in;

    typedef struct packed {
        logic                 ok;
        logic                 enqueue_valid;
        logic [BUF_IDX_W-1:0] enqueue_buffer;
        logic [TOTAL_W-1:0]   enqueue_total;
        logic [BUF_CNT_W-1:0] match_count;
        logic                 last;
    } t_out;

endpackage

FILE: sv/buffer_lease_tracker.sv
// ----------------------------------------------------------------------------
// buffer_lease_tracker
// Set request: the S_SET state registers the result once the output is free.
// Tick and count query: one table entry per cycle, a tick pausing while an
// earlier held release waits on the output; then the S_WALK state registers
// the result once the output is free. A tick emits one result per released
// buffer, or one when none is released. Requests are taken only in idle.
// Synchronous active-low reset: all buffers free, counters zero, registers
// back to 16 active buffers and lock_timeout 100.
// ----------------------------------------------------------------------------
module buffer_lease_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  blt_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output blt_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [blt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [blt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SET  = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [blt_pkg::NUM_BUF_W-1:0] r_active_bufs;
    logic [blt_pkg::TIMEOUT_W-1:0] r_lock_timeout;

    logic [1:0]                    r_status [blt_pkg::MAX_BUFFERS];
    logic [blt_pkg::SHARE_W-1:0]   r_share  [blt_pkg::MAX_BUFFERS];
    logic [blt_pkg::AGE_W-1:0]     r_age    [blt_pkg::MAX_BUFFERS];
    logic [blt_pkg::TOTAL_W-1:0]   r_enq_cnt, n_enq_cnt;

    blt_pkg::t_in                  r_req;
    logic [blt_pkg::BUF_CNT_W-1:0] r_idx, n_idx;
    logic [blt_pkg::BUF_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_hold_v, n_hold_v;
    logic [blt_pkg::BUF_IDX_W-1:0] r_hold_buf, n_hold_buf;
    logic [blt_pkg::TOTAL_W-1:0]   r_hold_total, n_hold_total;
    logic                          r_out_valid, n_out_valid;
    blt_pkg::t_out                 r_out, n_out;

    logic [blt_pkg::BUF_CNT_W-1:0] w_n;
    logic                          w_out_free;
    logic [blt_pkg::BUF_IDX_W-1:0] w_addr;
    logic [1:0]                    w_st_old, w_st_new;
    logic [blt_pkg::SHARE_W-1:0]   w_sh_old, w_sh_new, w_sh_inc, w_sh_dec;
    logic [blt_pkg::AGE_W-1:0]     w_age_old, w_age_new, w_age_tick;
    logic                          w_we;
    logic                          w_ok, w_enq;
    logic [blt_pkg::TOTAL_W-1:0]   w_enq_next;

    // walked entries: min(active buffers, MAX_BUFFERS)
    assign w_n = (r_active_bufs > blt_pkg::NUM_BUF_W'(blt_pkg::MAX_BUFFERS))
               ? blt_pkg::BUF_CNT_W'(blt_pkg::MAX_BUFFERS)
               : blt_pkg::BUF_CNT_W'(r_active_bufs);

    assign w_out_free  = ~r_out_valid | i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one shared entry port: the set request's buffer or the walk position
    assign w_addr     = (r_state == S_WALK) ? r_idx[blt_pkg::BUF_IDX_W-1:0]
                                            : r_req.buffer_index;
    assign w_st_old   = r_status[w_addr];
    assign w_sh_old   = r_share[w_addr];
    assign w_age_old  = r_age[w_addr];
    assign w_sh_inc   = (w_sh_old == '1) ? w_sh_old : w_sh_old + 1'b1;
    assign w_sh_dec   = (w_sh_old == '0) ? w_sh_old : w_sh_old - 1'b1;
    assign w_age_tick = (w_st_old == blt_pkg::STAT_LOCKED && w_age_old != '1)
                      ? w_age_old + 1'b1 : w_age_old;
    assign w_enq_next = r_enq_cnt + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_hold_v     = r_hold_v;
        n_hold_buf   = r_hold_buf;
        n_hold_total = r_hold_total;
        n_enq_cnt    = r_enq_cnt;
        n_out        = r_out;
        n_out_valid  = r_out_valid & ~i_out_ready;
        w_st_new     = w_st_old;
        w_sh_new     = w_sh_old;
        w_age_new    = w_age_old;
        w_we         = 1'b0;
        w_ok         = 1'b1;
        w_enq        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx    = '0;
                    n_cnt    = '0;
                    n_hold_v = 1'b0;
                    if (i_in_data.func == blt_pkg::FUNC_TICK ||
                        i_in_data.func == blt_pkg::FUNC_COUNT) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_SET;
                    end
                end
            end
            S_SET: begin
                if (w_out_free) begin
                    if (r_req.func != blt_pkg::FUNC_SET) begin
                        w_ok = 1'b0;
                    end else if ({1'b0, r_req.buffer_index} >= w_n) begin
                        w_ok = 1'b0;
                    end else begin
                        w_we = 1'b1;
                        case (w_st_old)
                            blt_pkg::STAT_IN_GRAPH: begin
                                if (r_req.requested_status == blt_pkg::STAT_LOCKED) begin
                                    w_sh_new = w_sh_inc;
                                    w_st_new = blt_pkg::STAT_LOCKED;
                                end else if (r_req.requested_status == blt_pkg::STAT_FREE) begin
                                    w_enq = ~r_req.already_enqueued;
                                end else begin
                                    w_ok = 1'b0;
                                end
                            end
                            blt_pkg::STAT_LOCKED: begin
                                if (r_req.requested_status == blt_pkg::STAT_LOCKED) begin
                                    w_sh_new  = w_sh_inc;
                                    w_age_new = '0;
                                end else if (r_req.requested_status == blt_pkg::STAT_FREE) begin
                                    w_sh_new = w_sh_dec;
                                    // a decrement from zero counts as reaching zero
                                    if (w_sh_dec == '0) begin
                                        w_st_new  = blt_pkg::STAT_IN_GRAPH;
                                        w_age_new = '0;
                                        w_enq     = 1'b1;
                                    end
                                end else begin
                                    w_ok = 1'b0;
                                end
                            end
                            default: begin
                                if (r_req.requested_status == blt_pkg::STAT_IN_GRAPH) begin
                                    w_st_new = blt_pkg::STAT_IN_GRAPH;
                                end else if (r_req.requested_status == blt_pkg::STAT_LOCKED) begin
                                    w_sh_new = w_sh_inc;
                                    w_st_new = blt_pkg::STAT_LOCKED;
                                end else begin
                                    w_ok = 1'b0;
                                end
                            end
                        endcase
                    end
                    if (w_enq) begin
                        n_enq_cnt = w_enq_next;
                    end
                    n_out.ok             = w_ok;
                    n_out.enqueue_valid  = w_enq;
                    n_out.enqueue_buffer = w_enq ? r_req.buffer_index : '0;
                    n_out.enqueue_total  = w_enq ? w_enq_next : r_enq_cnt;
                    n_out.match_count    = '0;
                    n_out.last           = 1'b1;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            S_WALK: begin
                if (r_idx < w_n) begin
                    if (r_req.func == blt_pkg::FUNC_TICK) begin
                        if (blt_pkg::AGE_W'(r_lock_timeout) == w_age_tick) begin
                            // release; an earlier held result goes out first, not last
                            if (!r_hold_v || w_out_free) begin
                                w_we         = 1'b1;
                                w_age_new    = '0;
                                w_sh_new     = '0;
                                w_st_new     = blt_pkg::STAT_IN_GRAPH;
                                n_enq_cnt    = w_enq_next;
                                n_hold_v     = 1'b1;
                                n_hold_buf   = r_idx[blt_pkg::BUF_IDX_W-1:0];
                                n_hold_total = w_enq_next;
                                n_idx        = r_idx + 1'b1;
                                if (r_hold_v) begin
                                    n_out.ok             = 1'b1;
                                    n_out.enqueue_valid  = 1'b1;
                                    n_out.enqueue_buffer = r_hold_buf;
                                    n_out.enqueue_total  = r_hold_total;
                                    n_out.match_count    = '0;
                                    n_out.last           = 1'b0;
                                    n_out_valid          = 1'b1;
                                end
                            end
                        end else begin
                            w_we      = 1'b1;
                            w_age_new = w_age_tick;
                            n_idx     = r_idx + 1'b1;
                        end
                    end else begin
                        if (w_st_old == r_req.requested_status) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                    end
                end else if (w_out_free) begin
                    n_out.ok             = 1'b1;
                    n_out.enqueue_valid  = r_hold_v;
                    n_out.enqueue_buffer = r_hold_v ? r_hold_buf : '0;
                    n_out.enqueue_total  = r_hold_v ? r_hold_total : r_enq_cnt;
                    n_out.match_count    = (r_req.func == blt_pkg::FUNC_COUNT) ? r_cnt : '0;
                    n_out.last           = 1'b1;
                    n_out_valid          = 1'b1;
                    n_hold_v             = 1'b0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_active_bufs  <= blt_pkg::NUM_BUF_RESET;
            r_lock_timeout <= blt_pkg::TIMEOUT_RESET;
            r_enq_cnt      <= '0;
            r_out_valid    <= 1'b0;
            r_hold_v       <= 1'b0;
            r_idx          <= '0;
            r_cnt          <= '0;
            for (int k = 0; k < blt_pkg::MAX_BUFFERS; k++) begin
                r_status[k] <= blt_pkg::STAT_FREE;
                r_share[k]  <= '0;
                r_age[k]    <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_enq_cnt   <= n_enq_cnt;
            r_out_valid <= n_out_valid;
            r_hold_v    <= n_hold_v;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    blt_pkg::CFG_ACTIVE_BUFS:
                        r_active_bufs <= i_cfg_data[blt_pkg::NUM_BUF_W-1:0];
                    blt_pkg::CFG_LOCK_TIMEOUT:
                        r_lock_timeout <= i_cfg_data[blt_pkg::TIMEOUT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_we) begin
                r_status[w_addr] <= w_st_new;
                r_share[w_addr]  <= w_sh_new;
                r_age[w_addr]    <= w_age_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_hold_buf   <= n_hold_buf;
        r_hold_total <= n_hold_total;
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in_data;
        end
    end

endmodule

FILE: sv/blt_checker.sv
// ----------------------------------------------------------------------------
// blt_checker
// Port-level checks for the buffer lease tracker, bound to the top level.
// ----------------------------------------------------------------------------
module blt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input blt_pkg::t_out o_out_data
);

    // a result waiting for transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after input transfer");

    a_enq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.enqueue_valid |-> o_out_data.ok &&
            o_out_data.match_count == '0)
        else $error("enqueue result without ok or with a count");

    a_enq_buf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.enqueue_valid |-> o_out_data.enqueue_buffer == '0 &&
            o_out_data.last)
        else $error("non-enqueue result malformed");

endmodule

bind buffer_lease_tracker blt_checker u_blt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: test/blt_lease_checker.sv
// ----------------------------------------------------------------------------
// blt_lease_checker
// Watches the request, result and register channels of the buffer lease
// tracker, predicts every result from its own copy of the buffer table and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module blt_lease_checker
    import blt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_outstanding,
    output int                    o_errors,
    output int                    o_checked,
    output int                    o_releases
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]           lease_state [MAX_BUFFERS];
    logic [SHARE_W-1:0]   lease_share [MAX_BUFFERS];
    logic [AGE_W-1:0]     lease_age   [MAX_BUFFERS];
    logic [TOTAL_W-1:0]   handback_total;
    logic [NUM_BUF_W-1:0] nbuf_cfg;
    logic [TIMEOUT_W-1:0] timeout_cfg;

    t_out due_results [$];

    function automatic logic [SHARE_W-1:0] share_up(input logic [SHARE_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic apply_request(input t_in req);
        t_out                 res;
        t_out                 held;
        logic                 have_held;
        logic                 granted;
        logic                 handback;
        logic [BUF_IDX_W-1:0] b;
        int                   span;
        int                   hits;
        span = (nbuf_cfg < MAX_BUFFERS) ? int'(nbuf_cfg) : MAX_BUFFERS;
        res = '0;
        held = '0;
        have_held = 1'b0;
        b = req.buffer_index;
        case (req.func)
            FUNC_SET: begin
                if (int'(b) < span) begin
                    granted = 1'b1;
                    handback = 1'b0;
                    case (lease_state[b])
                        STAT_IN_GRAPH: begin
                            if (req.requested_status == STAT_LOCKED) begin
                                lease_share[b] = share_up(lease_share[b]);
                                lease_state[b] = STAT_LOCKED;
                            end else if (req.requested_status == STAT_FREE) begin
                                handback = !req.already_enqueued;
                            end else begin
                                granted = 1'b0;
                            end
                        end
                        STAT_LOCKED: begin
                            if (req.requested_status == STAT_LOCKED) begin
                                lease_share[b] = share_up(lease_share[b]);
                                lease_age[b] = '0;
                            end else if (req.requested_status == STAT_FREE) begin
                                if (lease_share[b] != 0)
                                    lease_share[b] = lease_share[b] - 1'b1;
                                if (lease_share[b] == 0) begin
                                    lease_state[b] = STAT_IN_GRAPH;
                                    lease_age[b] = '0;
                                    handback = 1'b1;
                                end
                            end else begin
                                granted = 1'b0;
                            end
                        end
                        default: begin
                            if (req.requested_status == STAT_IN_GRAPH) begin
                                lease_state[b] = STAT_IN_GRAPH;
                            end else if (req.requested_status == STAT_LOCKED) begin
                                lease_share[b] = share_up(lease_share[b]);
                                lease_state[b] = STAT_LOCKED;
                            end else begin
                                granted = 1'b0;
                            end
                        end
                    endcase
                    if (handback)
                        handback_total = handback_total + 1'b1;
                    res.ok = granted;
                    res.enqueue_valid = handback;
                    res.enqueue_buffer = handback ? b : '0;
                end
            end
            FUNC_TICK: begin
                for (int i = 0; i < span; i++) begin
                    if (lease_state[i] == STAT_LOCKED && lease_age[i] != '1)
                        lease_age[i] = lease_age[i] + 1'b1;
                    if (lease_age[i] == timeout_cfg) begin
                        lease_age[i] = '0;
                        lease_share[i] = '0;
                        lease_state[i] = STAT_IN_GRAPH;
                        handback_total = handback_total + 1'b1;
                        o_releases++;
                        // only the final release of a tick carries last
                        if (have_held)
                            due_results.push_back(held);
                        held = '0;
                        held.ok = 1'b1;
                        held.enqueue_valid = 1'b1;
                        held.enqueue_buffer = BUF_IDX_W'(i);
                        held.enqueue_total = handback_total;
                        have_held = 1'b1;
                    end
                end
                if (have_held)
                    res = held;
                else
                    res.ok = 1'b1;
            end
            FUNC_COUNT: begin
                hits = 0;
                for (int i = 0; i < span; i++)
                    if (lease_state[i] == req.requested_status)
                        hits++;
                res.ok = 1'b1;
                res.match_count = BUF_CNT_W'(hits);
            end
            default: res.ok = 1'b0;
        endcase
        res.enqueue_total = handback_total;
        res.last = 1'b1;
        due_results.push_back(res);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BUFFERS; i++) begin
                lease_state[i] = STAT_FREE;
                lease_share[i] = '0;
                lease_age[i] = '0;
            end
            handback_total = '0;
            nbuf_cfg = NUM_BUF_RESET;
            timeout_cfg = TIMEOUT_RESET;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ACTIVE_BUFS)
                    nbuf_cfg = i_cfg_data[NUM_BUF_W-1:0];
                else if (i_cfg_index == CFG_LOCK_TIMEOUT)
                    timeout_cfg = i_cfg_data[TIMEOUT_W-1:0];
            end
            // a result transfer always belongs to an earlier request
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (due_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with nothing expected, expected none, actual %0h",
                             $time, i_out_data);
                end else begin
                    want = due_results.pop_front();
                    compare_field("ok", 32'(want.ok), 32'(i_out_data.ok));
                    compare_field("enqueue_valid", 32'(want.enqueue_valid),
                                  32'(i_out_data.enqueue_valid));
                    compare_field("enqueue_buffer", 32'(want.enqueue_buffer),
                                  32'(i_out_data.enqueue_buffer));
                    compare_field("enqueue_total", 32'(want.enqueue_total),
                                  32'(i_out_data.enqueue_total));
                    compare_field("match_count", 32'(want.match_count),
                                  32'(i_out_data.match_count));
                    compare_field("last", 32'(want.last), 32'(i_out_data.last));
                end
            end
            if (i_in_valid && i_in_ready)
                apply_request(i_in_data);
        end
        o_outstanding = due_results.size();
    end

endmodule

FILE: test/buffer_lease_tracker_tb.sv
// ----------------------------------------------------------------------------
// buffer_lease_tracker_tb
// Drives set, tick and count requests into the buffer lease tracker under
// several table sizes and lock timeouts, with bursty input, random output
// stalls and a long hold-off; the checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module buffer_lease_tracker_tb;

    import blt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF = 5;
    localparam int LIMIT_NS = 20_000_000;
    localparam int SETTLE   = MAX_BUFFERS + 8;
    localparam int PHASES   = 5;
    localparam int PER_PHASE = 50;

    // codes outside the package range
    localparam logic [1:0] FUNC_ILLEGAL = 2'd3;
    localparam logic [1:0] STAT_NONE    = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int outstanding;
    int errors;
    int checked;
    int releases;

    int  cur_nbuf = 16;
    int  burst_left = 0;
    int  sent = 0;
    int  cfg_writes = 0;
    int  hold_asked = 0;

    always #(CLK_HALF) clk = ~clk;

    buffer_lease_tracker DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    blt_lease_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_errors      (errors),
        .o_checked     (checked),
        .o_releases    (releases)
    );

    // result side stalls; a hold-off request blocks the output for a long stretch
    initial begin : sink_stalls
        int hold_served;
        int span;
        int mode;
        hold_served = 0;
        forever begin
            if (hold_asked != hold_served) begin
                hold_served++;
                repeat ($urandom_range(150, 250)) begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span) begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'($urandom_range(0, 1));
                        2: out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("buffer_lease_tracker_tb NOT OK");
        $finish;
    end

    function automatic t_in make_req(input logic [1:0] func, input int idx,
                                     input logic [1:0] status, input logic already);
        t_in req;
        req.func = func;
        req.buffer_index = BUF_IDX_W'(idx);
        req.requested_status = status;
        req.already_enqueued = already;
        return req;
    endfunction

    function automatic t_in random_request();
        t_in req;
        int  roll;
        int  pick;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 9) == 0)
            req.buffer_index = BUF_IDX_W'($urandom_range(0, 15));
        else
            req.buffer_index = BUF_IDX_W'($urandom_range(0, cur_nbuf - 1));
        req.already_enqueued = 1'($urandom_range(0, 1));
        req.requested_status = (pick < 3)  ? STAT_IN_GRAPH :
                               (pick < 11) ? STAT_LOCKED :
                               (pick < 19) ? STAT_FREE : STAT_NONE;
        if (roll < 60) begin
            req.func = FUNC_SET;
        end else if (roll < 85) begin
            req.func = FUNC_TICK;
        end else if (roll < 97) begin
            req.func = FUNC_COUNT;
            req.requested_status = 2'($urandom_range(0, 3));
        end else begin
            req.func = FUNC_ILLEGAL;
        end
        return req;
    endfunction

    // one request transfer; the sender works in bursts with random gaps
    task automatic put_request(input t_in req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input int nbuf, input int tmo);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ACTIVE_BUFS;
        cfg_data  <= CFG_DATA_W'(nbuf);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_LOCK_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(tmo);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_nbuf = nbuf;
        cfg_writes += 2;
    endtask

    // lock one buffer a few times, maybe age it, then hand it back
    task automatic lease_cycle();
        int b;
        int m;
        b = $urandom_range(0, cur_nbuf - 1);
        m = $urandom_range(1, 4);
        repeat (m) put_request(make_req(FUNC_SET, b, STAT_LOCKED, 1'b0));
        if ($urandom_range(0, 1) == 1)
            put_request(make_req(FUNC_TICK, 0, STAT_IN_GRAPH, 1'b0));
        repeat (m) put_request(make_req(FUNC_SET, b, STAT_FREE, 1'($urandom_range(0, 1))));
    endtask

    initial begin : stimulus
        int nbufs [PHASES];
        int tmos  [PHASES];
        int base;
        bit paused;
        nbufs = '{16, 2, 9, 5, 16};
        tmos  = '{3, 1, 7, 40, 6};
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table at reset size, timeout 100
        put_request(make_req(FUNC_COUNT, 0, STAT_FREE, 1'b0));
        put_request(make_req(FUNC_COUNT, 0, STAT_NONE, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_IN_GRAPH, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_IN_GRAPH, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_FREE, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_FREE, 1'b1));
        put_request(make_req(FUNC_SET, 15, STAT_LOCKED, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_LOCKED, 1'b1));
        put_request(make_req(FUNC_SET, 15, STAT_IN_GRAPH, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_NONE, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_FREE, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_FREE, 1'b0));
        put_request(make_req(FUNC_SET, 0, STAT_FREE, 1'b0));
        put_request(make_req(FUNC_SET, 0, STAT_LOCKED, 1'b0));
        put_request(make_req(FUNC_ILLEGAL, 15, STAT_NONE, 1'b1));
        put_request(make_req(FUNC_TICK, 0, STAT_IN_GRAPH, 1'b0));
        put_request(make_req(FUNC_COUNT, 0, STAT_LOCKED, 1'b0));
        put_request(make_req(FUNC_COUNT, 0, STAT_IN_GRAPH, 1'b0));

        // smallest table, shortest timeout: two releases in one tick, bad indexes
        set_config(2, 1);
        put_request(make_req(FUNC_SET, 0, STAT_LOCKED, 1'b0));
        put_request(make_req(FUNC_SET, 1, STAT_LOCKED, 1'b0));
        put_request(make_req(FUNC_TICK, 0, STAT_IN_GRAPH, 1'b0));
        put_request(make_req(FUNC_SET, 2, STAT_LOCKED, 1'b0));
        put_request(make_req(FUNC_SET, 15, STAT_IN_GRAPH, 1'b0));
        put_request(make_req(FUNC_COUNT, 0, STAT_IN_GRAPH, 1'b0));

        for (int p = 0; p < PHASES; p++) begin
            set_config(nbufs[p], tmos[p]);
            base = sent;
            if (p == PHASES - 1) begin
                // every buffer locked at the same age, then aged out in one tick
                for (int i = 0; i < MAX_BUFFERS; i++)
                    put_request(make_req(FUNC_SET, i, STAT_LOCKED, 1'b0));
                repeat (tmos[p]) put_request(make_req(FUNC_TICK, 0, STAT_IN_GRAPH, 1'b0));
            end
            while (sent - base < PER_PHASE) begin
                if (p == 0 && sent - base >= 20 && hold_asked == 0)
                    hold_asked <= 1;
                if (p == 2 && sent - base >= 27 && !paused) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 30)
                    lease_cycle();
                else
                    put_request(random_request());
            end
        end

        wait_drained();
        @(negedge clk);
        $display("run covered %0d requests and %0d results over %0d register writes",
                 sent, checked, cfg_writes);
        $display("timeout releases seen: %0d, with one long output hold-off and a full drain",
                 releases);
        if (errors == 0)
            $display("buffer_lease_tracker_tb OK");
        else
            $display("buffer_lease_tracker_tb NOT OK");
        $finish;
    end

endmodule
